// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Same-cycle property failed.");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Next-cycle property failed.");

`endif

// ===== rtl/rwr_pkg.sv =====
package rwr_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int MAX_PAYLOAD = 2047;
  localparam int SEQ_W       = 32;
  localparam int LEN_W       = 11;
  localparam int TAG_W       = 16;
  localparam int TOT_W       = 15;
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
  localparam int BIT_W       = $clog2(SEQ_W);

  typedef enum logic [2:0] {
    STS_DELIVERED    = 3'd0,
    STS_BUFFERED     = 3'd1,
    STS_BAD_CHECKSUM = 3'd2,
    STS_END          = 3'd3,
    STS_IGNORED      = 3'd4
  } status_e_t;

  typedef enum logic [2:0] {
    CLS_BAD,
    CLS_DROP,
    CLS_STORE,
    CLS_END,
    CLS_DATA
  } class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_REM
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic             is_end;
    logic             checksum_ok;
    logic [LEN_W-1:0] payload_length;
    logic [TAG_W-1:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    status_e_t        status;
    logic             deliver_valid;
    logic [LEN_W-1:0] deliver_length;
    logic [TAG_W-1:0] deliver_tag;
    logic             ack_valid;
    logic [SEQ_W-1:0] ack_num;
    logic [TOT_W-1:0] total_bytes;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic single;
    logic store;
    logic drain_init;
    logic drain_step;
    logic drain_final;
    logic cfg_write;
    logic rem_load;
  } ctrl_cmd_t;

  typedef struct packed {
    class_t cls;
    logic   drain_more;
    logic   rem_busy;
  } ctrl_sts_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
    logic [WIN_W-1:0] w;
    if (ws == '0) begin
      w = WIN_W'(1);
    end else if (32'(ws) > MAX_WINDOW) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = WIN_W'(ws);
    end
    return w;
  endfunction

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] x,
                                                 input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] s;
    s = WIN_W'(x) + WIN_W'(1);
    return (s >= w) ? '0 : s[SLOT_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] add_sat(input logic [TOT_W-1:0] t,
                                               input logic [LEN_W-1:0] l);
    logic [TOT_W:0] s;
    s = (TOT_W+1)'(t) + (TOT_W+1)'(l);
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] l);
    return (32'(l) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : l;
  endfunction

endpackage

// ===== rtl/rwr_rem.sv =====
module rwr_rem (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rwr_pkg::SEQ_W-1:0] dividend,
  input  logic [rwr_pkg::WIN_W-1:0] divisor,
  output logic                     busy,
  output logic [rwr_pkg::WIN_W-1:0] rem
);
  import rwr_pkg::*;

  logic [BIT_W-1:0] bit_idx;
  logic [WIN_W:0]   trial;
  logic [WIN_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dividend[bit_idx]};
    if (trial >= (WIN_W+1)'(divisor)) begin
      trial = trial - (WIN_W+1)'(divisor);
    end
    rem_next = trial[WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bit_idx == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      bit_idx <= BIT_W'(SEQ_W - 1);
    end else if (busy) begin
      rem     <= rem_next;
      bit_idx <= bit_idx - BIT_W'(1);
    end
  end

endmodule

// ===== rtl/rwr_ctrl.sv =====
module rwr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cfg_valid,
  output logic               busy,
  output logic               cfg_ready,
  output rwr_pkg::ctrl_cmd_t cmd,
  input  rwr_pkg::ctrl_sts_t sts
);
  import rwr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    cfg_ready  = (state == ST_IDLE) && !start;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end else if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          state_next    = ST_REM;
        end
      end
      ST_EVAL: begin
        if (sts.cls == CLS_DATA) begin
          cmd.drain_init = 1'b1;
          state_next     = ST_DRAIN;
        end else begin
          cmd.single = 1'b1;
          cmd.store  = (sts.cls == CLS_STORE);
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (sts.drain_more) begin
          cmd.drain_step = 1'b1;
        end else begin
          cmd.drain_final = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_REM: begin
        if (!sts.rem_busy) begin
          cmd.rem_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rwr_dp.sv =====
module rwr_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  rwr_pkg::in_item_t         item,
  input  logic [rwr_pkg::CFG_W-1:0] cfg_data,
  input  rwr_pkg::ctrl_cmd_t        cmd,
  output rwr_pkg::ctrl_sts_t        sts,
  output logic                      result_valid,
  output rwr_pkg::out_item_t        result
);
  import rwr_pkg::*;

  `include "assert_macros.svh"

  logic [CFG_W-1:0]      window_cfg;
  logic [SEQ_W-1:0]      expected_seq;
  logic [SLOT_W-1:0]     exp_mod;
  in_item_t              pkt;
  logic [MAX_WINDOW-1:0] slot_valid;
  logic [LEN_W-1:0]      slot_length [MAX_WINDOW];
  logic [TAG_W-1:0]      slot_tag [MAX_WINDOW];
  logic [LEN_W-1:0]      rd_length;
  logic [TAG_W-1:0]      rd_tag;
  logic [SLOT_W-1:0]     idx;
  logic [SEQ_W-1:0]      next_seq;
  logic [WIN_W-1:0]      cnt;
  logic [LEN_W-1:0]      pend_length;
  logic [TAG_W-1:0]      pend_tag;
  logic [TOT_W-1:0]      total;

  logic [WIN_W-1:0]      w_eff;
  logic [SEQ_W-1:0]      diff;
  logic [WIN_W:0]        store_sum;
  logic [SLOT_W-1:0]     store_idx;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  rem_busy;
  logic [WIN_W-1:0]      rem;
  class_t                cls;
  out_item_t             res_next;
  in_item_t              item_sat;

  assign w_eff = eff_window(window_cfg);
  assign diff  = pkt.seq_num - expected_seq;

  always_comb begin
    item_sat                = item;
    item_sat.payload_length = sat_len(item.payload_length);
  end

  always_comb begin
    store_sum = (WIN_W+1)'(exp_mod) + (WIN_W+1)'(diff[WIN_W-1:0]);
    if (store_sum >= (WIN_W+1)'(w_eff)) begin
      store_sum = store_sum - (WIN_W+1)'(w_eff);
    end
    store_idx = store_sum[SLOT_W-1:0];
  end

  always_comb begin
    if (!pkt.checksum_ok) begin
      cls = CLS_BAD;
    end else if (pkt.seq_num > expected_seq) begin
      cls = (diff >= SEQ_W'(w_eff)) ? CLS_DROP : CLS_STORE;
    end else if (pkt.seq_num < expected_seq) begin
      cls = CLS_DROP;
    end else if (pkt.is_end) begin
      cls = CLS_END;
    end else begin
      cls = CLS_DATA;
    end
  end

  assign sts.cls        = cls;
  assign sts.drain_more = (cnt < w_eff) && (next_seq != '0) && slot_valid[idx];
  assign sts.rem_busy   = rem_busy;

  assign rd_addr = cmd.drain_init ? wrap_inc(exp_mod, w_eff) : wrap_inc(idx, w_eff);

  rwr_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.cfg_write),
    .dividend (expected_seq),
    .divisor  (w_eff),
    .busy     (rem_busy),
    .rem      (rem)
  );

  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    if (cmd.drain_step || cmd.drain_final) begin
      res_next.status         = STS_DELIVERED;
      res_next.deliver_valid  = 1'b1;
      res_next.deliver_length = pend_length;
      res_next.deliver_tag    = pend_tag;
      res_next.total_bytes    = total;
      res_next.last           = cmd.drain_final;
      res_next.ack_valid      = cmd.drain_final;
      res_next.ack_num        = cmd.drain_final ? next_seq : '0;
    end else begin
      case (cls)
        CLS_BAD: begin
          res_next.status = STS_BAD_CHECKSUM;
        end
        CLS_STORE: begin
          res_next.status    = STS_BUFFERED;
          res_next.ack_valid = 1'b1;
          res_next.ack_num   = expected_seq;
        end
        CLS_END: begin
          res_next.status    = STS_END;
          res_next.ack_valid = 1'b1;
          res_next.ack_num   = pkt.seq_num;
        end
        default: begin
          res_next.status = STS_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cfg   <= CFG_W'(MAX_WINDOW);
      expected_seq <= '0;
      exp_mod      <= '0;
      slot_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.single || cmd.drain_step || cmd.drain_final;
      if (cmd.cfg_write) begin
        window_cfg <= cfg_data;
        slot_valid <= '0;
      end
      if (cmd.rem_load) begin
        exp_mod <= rem[SLOT_W-1:0];
      end
      if (cmd.store) begin
        slot_valid[store_idx] <= 1'b1;
      end
      if (cmd.drain_step) begin
        slot_valid[idx] <= 1'b0;
      end
      if (cmd.drain_final) begin
        expected_seq <= next_seq;
        exp_mod      <= (next_seq == '0) ? '0 : idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      slot_length[store_idx] <= pkt.payload_length;
      slot_tag[store_idx]    <= pkt.payload_tag;
    end
    rd_length <= slot_length[rd_addr];
    rd_tag    <= slot_tag[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pkt <= item_sat;
    end
    if (cmd.single || cmd.drain_step || cmd.drain_final) begin
      result <= res_next;
    end
    if (cmd.drain_init) begin
      next_seq    <= expected_seq + SEQ_W'(1);
      idx         <= wrap_inc(exp_mod, w_eff);
      cnt         <= WIN_W'(1);
      pend_length <= pkt.payload_length;
      pend_tag    <= pkt.payload_tag;
      total       <= add_sat('0, pkt.payload_length);
    end else if (cmd.drain_step) begin
      next_seq    <= next_seq + SEQ_W'(1);
      idx         <= wrap_inc(idx, w_eff);
      cnt         <= cnt + WIN_W'(1);
      pend_length <= rd_length;
      pend_tag    <= rd_tag;
      total       <= add_sat(total, rd_length);
    end
  end

  `ASSERT_NEXT(a_more_follows, clk, rst, result_valid && !result.last, result_valid)
  `ASSERT_SAME(a_ack_on_last, clk, rst, result_valid && result.ack_valid, result.last)
  `ASSERT_SAME(a_store_in_window, clk, rst, cmd.store, store_sum < (WIN_W+1)'(w_eff))

endmodule

// ===== rtl/reorder_window_receiver_unit.sv =====
// A result that stands alone is strobed once start is accepted and the packet has been
// registered and classified in the evaluate state. A packet in order that releases k
// stored packets strobes k+1 results on consecutive cycles from the drain state; busy is
// high through evaluate and drain, so no packet is taken until the one-slot-a-cycle
// drain loop ends. A window write runs a bit-serial remainder pass, with busy high.
// Synchronous reset: window 16, expected number zero, all slots empty, no result.
module reorder_window_receiver_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rwr_pkg::in_item_t         item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rwr_pkg::CFG_W-1:0] cfg_data,
  output logic                      result_valid,
  output rwr_pkg::out_item_t        result
);
  import rwr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rwr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== bench/tb_reorder_window_receiver_unit.sv =====
`timescale 1ns / 1ps
module tb_reorder_window_receiver_unit;
  import rwr_pkg::*;

  localparam int IDLE_LOW = 7;
  localparam int IDLE_HIGH = 66;
  localparam int MAX_REPORTS = 10;
  localparam int BYTE_CAP = 32767;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_PACKETS = 12;

  typedef enum int {
    NOISE_STALE,
    NOISE_BEYOND,
    NOISE_ANY
  } noise_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  out_item_t result;

  logic [CFG_W-1:0] window_reg = CFG_W'(16);
  logic [SEQ_W-1:0] next_expected = '0;
  logic [MAX_WINDOW-1:0] slot_held = '0;
  logic [LEN_W-1:0] slot_len [MAX_WINDOW];
  logic [TAG_W-1:0] slot_handle [MAX_WINDOW];

  in_item_t pending_packets[$];
  out_item_t awaited_results[$];
  int unsigned sender_idle_pct = IDLE_LOW;
  int unsigned mismatch_count = 0;
  int unsigned packets_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned window_writes = 0;

  reorder_window_receiver_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic int unsigned span(input logic [CFG_W-1:0] ws);
    if (ws == '0) begin
      return 1;
    end
    if (ws > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return 32'(ws);
  endfunction

  function automatic in_item_t make_packet(input logic [SEQ_W-1:0] seq, input bit fin,
                                           input bit ok, input logic [LEN_W-1:0] len,
                                           input logic [TAG_W-1:0] tag);
    in_item_t p;
    p.seq_num = seq;
    p.is_end = fin;
    p.checksum_ok = ok;
    p.payload_length = len;
    p.payload_tag = tag;
    return p;
  endfunction

  function automatic out_item_t make_result(input status_e_t st, input bit dv,
                                            input logic [LEN_W-1:0] dl,
                                            input logic [TAG_W-1:0] dt, input bit av,
                                            input logic [SEQ_W-1:0] an,
                                            input int unsigned tb, input bit ls);
    out_item_t r;
    r.status = st;
    r.deliver_valid = dv;
    r.deliver_length = dl;
    r.deliver_tag = dt;
    r.ack_valid = av;
    r.ack_num = an;
    r.total_bytes = TOT_W'(tb);
    r.last = ls;
    return r;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("status=%0d dv=%0b len=%0d tag=%h ack=%0b num=%h total=%0d last=%0b",
                     r.status, r.deliver_valid, r.deliver_length, r.deliver_tag,
                     r.ack_valid, r.ack_num, r.total_bytes, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void predict_packet(input in_item_t p);
    int unsigned w;
    int unsigned s;
    int unsigned d;
    int unsigned total;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pend_len;
    logic [TAG_W-1:0] pend_tag;
    logic [SEQ_W-1:0] nxt;
    bit stop;
    w = span(window_reg);
    len = p.payload_length;
    if (len > MAX_PAYLOAD) begin
      len = LEN_W'(MAX_PAYLOAD);
    end
    if (!p.checksum_ok) begin
      awaited_results.push_back(make_result(STS_BAD_CHECKSUM, 0, 0, 0, 0, 0, 0, 1));
    end else if (p.seq_num > next_expected) begin
      if (p.seq_num - next_expected >= w) begin
        awaited_results.push_back(make_result(STS_IGNORED, 0, 0, 0, 0, 0, 0, 1));
      end else begin
        s = p.seq_num % w;
        slot_held[s] = 1'b1;
        slot_len[s] = len;
        slot_handle[s] = p.payload_tag;
        awaited_results.push_back(make_result(STS_BUFFERED, 0, 0, 0, 1, next_expected, 0, 1));
      end
    end else if (p.seq_num < next_expected) begin
      awaited_results.push_back(make_result(STS_IGNORED, 0, 0, 0, 0, 0, 0, 1));
    end else if (p.is_end) begin
      awaited_results.push_back(make_result(STS_END, 0, 0, 0, 1, p.seq_num, 0, 1));
    end else begin
      total = len;
      pend_len = len;
      pend_tag = p.payload_tag;
      nxt = next_expected + 1;
      stop = 1'b0;
      for (d = 1; d < w && !stop; d++) begin
        s = nxt % w;
        if (nxt == '0 || !slot_held[s]) begin
          stop = 1'b1;
        end else begin
          awaited_results.push_back(make_result(STS_DELIVERED, 1, pend_len, pend_tag,
                                                0, 0, total, 0));
          slot_held[s] = 1'b0;
          pend_len = slot_len[s];
          pend_tag = slot_handle[s];
          total = total + pend_len;
          if (total > BYTE_CAP) begin
            total = BYTE_CAP;
          end
          nxt = nxt + 1;
        end
      end
      next_expected = nxt;
      awaited_results.push_back(make_result(STS_DELIVERED, 1, pend_len, pend_tag,
                                            1, nxt, total, 1));
    end
  endfunction

  function automatic in_item_t noise_packet(input logic [SEQ_W-1:0] base,
                                            input int unsigned w);
    logic [SEQ_W-1:0] seq;
    noise_kind_t kind;
    kind = noise_kind_t'($urandom_range(2, 0));
    case (kind)
      NOISE_STALE: begin
        seq = (base == '0) ? SEQ_W'($urandom) : base - 1 - ($urandom % base);
      end
      NOISE_BEYOND: begin
        seq = base + w + $urandom_range(100, 0);
      end
      default: begin
        seq = $urandom;
      end
    endcase
    return make_packet(seq, $urandom_range(99, 0) < 20, $urandom_range(99, 0) >= 6,
                       $urandom_range(MAX_PAYLOAD, 0), $urandom);
  endfunction

  function automatic int queue_burst();
    int unsigned w;
    int unsigned k;
    int unsigned j;
    int unsigned pick;
    int counted;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] order[$];
    w = span(window_reg);
    base = next_expected;
    counted = 0;
    k = ($urandom_range(1, 0) == 1) ? w : $urandom_range(w, 1);
    for (j = 0; j < k; j++) begin
      order.push_back(base + j);
    end
    for (j = k - 1; j > 0; j--) begin
      pick = $urandom_range(j, 0);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    if ($urandom_range(99, 0) < 30) begin
      for (j = 0; j < k; j++) begin
        order[j] = base + ((j + 1) % k);
      end
    end
    for (j = 0; j < k; j++) begin
      if ($urandom_range(99, 0) < 15) begin
        pending_packets.push_back(noise_packet(base, w));
      end
      pending_packets.push_back(make_packet(order[j], $urandom_range(99, 0) < 8,
                                            $urandom_range(99, 0) >= 6,
                                            $urandom_range(MAX_PAYLOAD, 0), $urandom));
      counted++;
      if ($urandom_range(99, 0) < 8) begin
        pending_packets.push_back(make_packet(order[j], 1'b0, 1'b1,
                                              $urandom_range(MAX_PAYLOAD, 0), $urandom));
        counted++;
      end
    end
    return counted;
  endfunction

  task automatic wait_accepted();
    while (pending_packets.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_packets.size() != 0 || start || awaited_results.size() != 0 || busy) begin
      @(negedge clk);
    end
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_reg = value;
    slot_held = '0;
    window_writes++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_packet(item);
        packets_accepted++;
        void'(pending_packets.pop_front());
      end
      if (!start || !busy) begin
        if (pending_packets.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          start <= 1'b1;
          item <= pending_packets[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result %s", describe(result)));
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (result.status !== want.status || result.deliver_valid !== want.deliver_valid ||
            result.deliver_length !== want.deliver_length ||
            result.deliver_tag !== want.deliver_tag || result.ack_valid !== want.ack_valid ||
            result.ack_num !== want.ack_num || result.total_bytes !== want.total_bytes ||
            result.last !== want.last) begin
          note_failure($sformatf("expected %s, got %s", describe(want), describe(result)));
        end
      end
    end
  end

  initial begin
    int unsigned seg;
    int got;
    logic [CFG_W-1:0] settings [SEGMENTS];
    settings = '{5'd5, 5'd1, 5'd0, 5'd31, 5'd16, 5'd0};
    settings[SEGMENTS-1] = CFG_W'($urandom_range(31, 0));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_packets.push_back(make_packet(0, 0, 0, 0, 16'h0000));
    pending_packets.push_back(make_packet(0, 0, 1, 2047, 16'hFFFF));
    pending_packets.push_back(make_packet(3, 0, 1, 0, 16'h0000));
    pending_packets.push_back(make_packet(2, 1, 1, 17, 16'h00A5));
    pending_packets.push_back(make_packet(3, 0, 1, 100, 16'h1234));
    pending_packets.push_back(make_packet(1, 0, 1, 300, 16'h5A5A));
    pending_packets.push_back(make_packet(4, 1, 1, 5, 16'h0001));
    pending_packets.push_back(make_packet(0, 0, 1, 9, 16'h0002));
    pending_packets.push_back(make_packet(20, 0, 1, 1024, 16'h8000));
    pending_packets.push_back(make_packet(19, 0, 1, 1023, 16'h7FFF));
    pending_packets.push_back(make_packet(32'hFFFF_FFFF, 1, 1, 2047, 16'hFFFF));
    pending_packets.push_back(make_packet(5, 1, 0, 2047, 16'hFFFF));
    pending_packets.push_back(make_packet(4, 0, 1, 1, 16'hC3C3));
    wait_idle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      sender_idle_pct = (seg < 2) ? IDLE_LOW : (seg < 4) ? IDLE_HIGH : 0;
      write_window(settings[seg]);
      got = 0;
      while (got < SEGMENT_PACKETS) begin
        got += queue_burst();
        wait_accepted();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    end
    $display("Run covered %0d packets and %0d window writes; %0d results were checked.",
             packets_accepted, window_writes, results_checked);
    $display("Mismatches counted: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout: the run did not reach its end.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
